// ===== design/digipot_updown_stepper_top_macros.svh =====
// Assertion helpers used by the stepper top level.
`ifndef DIGIPOT_UPDOWN_STEPPER_TOP_MACROS_SVH
`define DIGIPOT_UPDOWN_STEPPER_TOP_MACROS_SVH

// Check a property on every rising edge of clk, idle while arst_n is low.
`define DPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define DPS_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== design/dpstep_pkg.sv =====
`default_nettype none

package dpstep_pkg;

	// Default configuration of the potentiometer
	localparam int unsigned NUM_POSITIONS_DEF = 128;
	localparam int unsigned RESET_EXTRA_DEF   = 10;

	// Percent command range
	localparam int unsigned MAX_PERCENT = 100;
	localparam int unsigned PCT_W       = 7;
	localparam int unsigned PCT_ENTRIES = 1 << PCT_W;
	localparam int unsigned POS_W       = 7;
	localparam int unsigned LUT_W       = 8;

	// Input word kinds
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	// One input word after unpacking
	typedef struct packed {
		op_t              op;
		logic [PCT_W-1:0] percent;
		logic             req;
	} cmd_t;

	// One result word before packing
	typedef struct packed {
		logic             clock_pin;
		logic             direction_pin;
		logic [POS_W-1:0] position;
		logic             resetting;
		logic             active;
		logic             range_error;
	} res_t;

	// Percent to target step table
	typedef logic [LUT_W-1:0] pct_lut_t [PCT_ENTRIES];

	// Build floor(percent*(npos-1)/100) for every legal percent
	function automatic pct_lut_t build_pct_lut(int unsigned npos);
		pct_lut_t lut;
		for (int unsigned p = 0; p < PCT_ENTRIES; p++) begin
			if (p <= MAX_PERCENT) begin
				lut[p] = LUT_W'((p * (npos - 1)) / MAX_PERCENT);
			end else begin
				lut[p] = '0;
			end
		end
		return lut;
	endfunction

endpackage

`default_nettype wire

// ===== design/dpstep_core.sv =====
`default_nettype none

module dpstep_core import dpstep_pkg::*; #(
	parameter int unsigned NUM_POSITIONS      = NUM_POSITIONS_DEF,
	parameter int unsigned RESET_EXTRA_PULSES = RESET_EXTRA_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire cmd_t cmd,
	output res_t      res
);

	localparam int unsigned SW = (NUM_POSITIONS > 2) ? $clog2(NUM_POSITIONS) : 1;
	localparam int unsigned PW = $clog2(NUM_POSITIONS + RESET_EXTRA_PULSES + 1);
	localparam logic [SW-1:0] TopStep = SW'(NUM_POSITIONS - 1);
	localparam logic [PW-1:0] RunLen  = PW'(NUM_POSITIONS + RESET_EXTRA_PULSES);
	localparam pct_lut_t PctLut = build_pct_lut(NUM_POSITIONS);

	logic          clk_q, dir_q, en_q;
	logic [SW-1:0] step_q, tgt_q;
	logic [PW-1:0] pulses_q;

	logic          clk_n, dir_n, en_n, rerr;
	logic [SW-1:0] step_n, tgt_n;
	logic [PW-1:0] pulses_n;
	logic [LUT_W-1:0] lut_val;
	logic [SW+POS_W-1:0] pos_ext;

	assign lut_val = PctLut[cmd.percent];

	// Next state for one word
	always_comb begin
		clk_n    = clk_q;
		dir_n    = dir_q;
		en_n     = en_q;
		step_n   = step_q;
		tgt_n    = tgt_q;
		pulses_n = pulses_q;
		rerr     = 1'b0;
		case (cmd.op)
			OP_SET: begin
				if (cmd.percent > PCT_W'(MAX_PERCENT)) begin
					rerr = 1'b1;
				end else begin
					tgt_n = lut_val[SW-1:0];
					// restart the reset run if asked or still pending
					if (pulses_q != '0 || cmd.req) begin
						pulses_n = RunLen;
						dir_n    = 1'b1;
						step_n   = '0;
					end
					en_n = 1'b1;
				end
			end
			OP_TICK: begin
				if (en_q) begin
					if (!clk_q) begin
						clk_n = 1'b1;
						if (pulses_q == '0 && step_q == tgt_q) begin
							en_n = 1'b0;
						end
					end else if (pulses_q != '0) begin
						pulses_n = pulses_q - PW'(1);
						if (pulses_q == PW'(1)) begin
							step_n = TopStep;
						end
						clk_n = 1'b0;
					end else if (step_q < tgt_q) begin
						dir_n  = 1'b1;
						step_n = step_q + SW'(1);
						clk_n  = 1'b0;
					end else if (step_q > tgt_q) begin
						dir_n  = 1'b0;
						step_n = step_q - SW'(1);
						clk_n  = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Report the state after this word
	assign pos_ext = {{POS_W{1'b0}}, step_n};

	always_comb begin
		res.clock_pin     = clk_n;
		res.direction_pin = dir_n;
		res.position      = (pulses_n != '0) ? '0 : pos_ext[POS_W-1:0];
		res.resetting     = (pulses_n != '0);
		res.active        = en_n;
		res.range_error   = rerr;
	end

	// Commit state as the word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q    <= 1'b1;
			dir_q    <= 1'b1;
			en_q     <= 1'b1;
			step_q   <= '0;
			tgt_q    <= TopStep;
			pulses_q <= RunLen;
		end else if (adv) begin
			clk_q    <= clk_n;
			dir_q    <= dir_n;
			en_q     <= en_n;
			step_q   <= step_n;
			tgt_q    <= tgt_n;
			pulses_q <= pulses_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/digipot_updown_stepper_top.sv =====
// Channel  Dir  tdata (low bit up)                                 tuser
// s_*      in   set_percent[6:0] reset_request[7]                  opcode
// m_*      out  clock_pin direction_pin position[6:0] resetting    -
//               active range_error, zero filled to 16 bits
//
// One word per cycle sustained while m_tready stays high; m_tvalid rises once
// an accepted word has passed the input register, then the result register.
// The position/target update is one short pass between those registers.
// arst_n puts the driver in a full reset run toward the top step.
// A stalled m_tready holds the result; the input register still takes one
// more word, and s_tready drops only when both stages are full.
`default_nettype none

`include "digipot_updown_stepper_top_macros.svh"

module digipot_updown_stepper_top import dpstep_pkg::*; #(
	parameter int unsigned NUM_POSITIONS      = NUM_POSITIONS_DEF,
	parameter int unsigned RESET_EXTRA_PULSES = RESET_EXTRA_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // set_percent[6:0], reset_request[7]
	input  wire logic        s_tuser,   // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // clock_pin, direction_pin, position[6:0],
	                                    // resetting, active, range_error, pad
);

	logic v_s1;
	cmd_t cmd_s1;
	logic adv;
	res_t res_c;
	res_t res_q;
	logic out_v_q;

	// Move the input word on when the result register is free or drains
	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.op      <= op_t'(s_tuser);
			cmd_s1.percent <= s_tdata[PCT_W-1:0];
			cmd_s1.req     <= s_tdata[PCT_W];
		end
	end

	dpstep_core #(
		.NUM_POSITIONS      (NUM_POSITIONS),
		.RESET_EXTRA_PULSES (RESET_EXTRA_PULSES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cmd    (cmd_s1),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, res_q.range_error, res_q.active, res_q.resetting,
	                   res_q.position, res_q.direction_pin, res_q.clock_pin};

	// A held input word must not be overwritten
	`DPS_ASSERT_NEXT(a_s1_hold, v_s1 && !adv, v_s1 && $stable(cmd_s1), "input word lost")
	// The reset run always drives the wiper up
	`DPS_ASSERT(a_reset_dir, out_v_q && res_q.resetting |-> res_q.direction_pin,
		"direction low during reset run")
	// Stepping only stops with the clock pin high
	`DPS_ASSERT(a_idle_clk, out_v_q && !res_q.active |-> res_q.clock_pin,
		"stepping stopped with clock low")

endmodule

`default_nettype wire

// ===== verif/digipot_updown_stepper_checker.sv =====
// Watches both stream channels of the stepper, predicts each result word from
// the accepted input words and compares the two field by field.
module digipot_updown_stepper_checker import dpstep_pkg::*; #(
	parameter int unsigned NUM_POSITIONS      = NUM_POSITIONS_DEF,
	parameter int unsigned RESET_EXTRA_PULSES = RESET_EXTRA_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // set_percent[6:0], reset_request[7]
	input  logic        s_tuser,   // opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // clock_pin, direction_pin, position[6:0],
	                               // resetting, active, range_error, pad
	output int          fail_count,
	output int          pending_words,
	output int          words_checked,
	output int          sets_taken,
	output int          sets_rejected,
	output int          runs_finished,
	output int          targets_reached
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the driver state
	logic             clk_lvl;
	logic             dir_up;
	logic             enabled;
	logic [POS_W-1:0] wiper;
	logic [POS_W-1:0] target;
	logic [7:0]       pulses_left;

	// Result words still owed by the block, oldest first
	res_t expected_pins[$];
	res_t want;

	int mismatches = 0;
	int checked    = 0;
	int sets_n     = 0;
	int rejected_n = 0;
	int runs_n     = 0;
	int reached_n  = 0;

	// Advance the shadow state by one input word and return the pin levels
	function automatic res_t step_wiper(op_t op, logic [PCT_W-1:0] pct, logic req);
		res_t r;
		r = '0;
		if (op == OP_SET) begin
			if (pct > MAX_PERCENT) begin
				r.range_error = 1'b1;
				rejected_n++;
			end else begin
				target = POS_W'((int'(pct) * (NUM_POSITIONS - 1)) / MAX_PERCENT);
				// restart the pulse run when asked or when one is still going
				if (pulses_left != 0 || req) begin
					pulses_left = 8'(NUM_POSITIONS + RESET_EXTRA_PULSES);
					dir_up      = 1'b1;
					wiper       = '0;
				end
				enabled = 1'b1;
				sets_n++;
			end
		end else if (enabled) begin
			if (!clk_lvl) begin
				clk_lvl = 1'b1;
				if (pulses_left == 0 && wiper == target) begin
					enabled = 1'b0;
					reached_n++;
				end
			end else if (pulses_left != 0) begin
				pulses_left = pulses_left - 8'd1;
				if (pulses_left == 0) begin
					wiper = POS_W'(NUM_POSITIONS - 1);
					runs_n++;
				end
				clk_lvl = 1'b0;
			end else if (wiper < target) begin
				dir_up  = 1'b1;
				wiper   = wiper + 1'b1;
				clk_lvl = 1'b0;
			end else if (wiper > target) begin
				dir_up  = 1'b0;
				wiper   = wiper - 1'b1;
				clk_lvl = 1'b0;
			end
		end
		r.clock_pin     = clk_lvl;
		r.direction_pin = dir_up;
		r.position      = (pulses_left != 0) ? '0 : wiper;
		r.resetting     = (pulses_left != 0);
		r.active        = enabled;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// hardware reset starts a full run toward the top step
			clk_lvl     = 1'b1;
			dir_up      = 1'b1;
			enabled     = 1'b1;
			wiper       = '0;
			target      = POS_W'(NUM_POSITIONS - 1);
			pulses_left = 8'(NUM_POSITIONS + RESET_EXTRA_PULSES);
			expected_pins.delete();
		end else begin
			// compare a delivered word with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_pins.size() == 0) begin
					$error("result word %h arrived with nothing expected", m_tdata);
					mismatches++;
				end else begin
					want = expected_pins.pop_front();
					check_field("clock_pin", want.clock_pin, m_tdata[0]);
					check_field("direction_pin", want.direction_pin, m_tdata[1]);
					check_field("position", want.position, m_tdata[8:2]);
					check_field("resetting", want.resetting, m_tdata[9]);
					check_field("active", want.active, m_tdata[10]);
					check_field("range_error", want.range_error, m_tdata[11]);
					check_field("pad", 0, m_tdata[15:12]);
					checked++;
				end
			end
			// predict the word for each accepted input
			if (s_tvalid && s_tready) begin
				expected_pins.push_back(step_wiper(op_t'(s_tuser), s_tdata[PCT_W-1:0],
					s_tdata[7]));
			end
		end
		fail_count      <= mismatches;
		pending_words   <= expected_pins.size();
		words_checked   <= checked;
		sets_taken      <= sets_n;
		sets_rejected   <= rejected_n;
		runs_finished   <= runs_n;
		targets_reached <= reached_n;
	end

endmodule

// ===== verif/digipot_updown_stepper_top_tb.sv =====
// Stimulus and verdict for the up/down potentiometer stepper.
module digipot_updown_stepper_top_tb import dpstep_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS = 1350;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int fail_count;
	int pending_words;
	int words_checked;
	int sets_taken;
	int sets_rejected;
	int runs_finished;
	int targets_reached;

	int items_sent = 0;
	int tx_gap_pct = 0;
	int rx_gap_pct = 0;
	int taken      = 0;
	bit quiet      = 1'b0;
	bit held       = 1'b0;

	digipot_updown_stepper_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	digipot_updown_stepper_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.pending_words   (pending_words),
		.words_checked   (words_checked),
		.sets_taken      (sets_taken),
		.sets_rejected   (sets_rejected),
		.runs_finished   (runs_finished),
		.targets_reached (targets_reached)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one word, maybe after an idle burst, and hold it until taken
	task automatic push_word(op_t op, logic [PCT_W-1:0] pct, logic req);
		// no idling on either side near the end of the run
		if (items_sent >= ITEMS - 200) begin
			quiet = 1'b1;
		end
		if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {req, pct};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic push_tick();
		push_word(OP_TICK, PCT_W'($urandom), 1'($urandom));
	endtask

	// Sender
	initial begin
		logic [PCT_W-1:0] last_pct;
		int               n;
		last_pct = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks during the power-up run, with every data bit set and clear
		push_word(OP_TICK, '1, 1'b1);
		push_word(OP_TICK, '0, 1'b0);
		// out-of-range percents are flagged and change nothing
		push_word(OP_SET, 7'd127, 1'b0);
		push_word(OP_SET, 7'd101, 1'b1);
		// a set while the run is pending restarts it
		push_word(OP_SET, 7'd100, 1'b0);
		push_word(OP_SET, 7'd0, 1'b1);
		repeat (3) push_tick();
		push_word(OP_SET, 7'd1, 1'b0);
		push_word(OP_SET, 7'd99, 1'b1);
		push_word(OP_SET, 7'd50, 1'b0);
		repeat (4) push_tick();

		// random set commands, each followed by a run of ticks
		while (items_sent < ITEMS) begin
			case ($urandom_range(0, 2))
				0: begin
					tx_gap_pct = 0;
				end
				1: begin
					tx_gap_pct = 8;
				end
				default: begin
					tx_gap_pct = 35;
				end
			endcase
			case ($urandom_range(0, 9))
				0: begin
					push_word(OP_SET, PCT_W'($urandom_range(101, 127)), 1'($urandom));
				end
				1, 2: begin
					// same target again, often right where the wiper sits
					push_word(OP_SET, last_pct, 1'b0);
				end
				default: begin
					last_pct = PCT_W'($urandom_range(0, 100));
					push_word(OP_SET, last_pct, $urandom_range(0, 4) == 0);
				end
			endcase
			case ($urandom_range(0, 2))
				0: begin
					n = $urandom_range(0, 30);
				end
				1: begin
					n = $urandom_range(30, 200);
				end
				default: begin
					n = $urandom_range(200, 600);
				end
			endcase
			// stop the tick run at the item budget
			if (n > ITEMS - items_sent) begin
				n = ITEMS - items_sent;
			end
			repeat (n) push_tick();
		end
		s_tvalid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_words != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d result words; %0d set commands taken, %0d rejected.",
			words_checked, sets_taken, sets_rejected);
		$display("Pulse runs finished: %0d, targets reached with stepping stopped: %0d.",
			runs_finished, targets_reached);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver: random stalls, one long hold-off, none near the end
	initial begin
		int iter;
		iter = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (iter % 150 == 0) begin
				rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
			end
			iter++;
			if (!held && taken >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (120) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < rx_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
				if (m_tvalid) begin
					taken++;
				end
			end
		end
	end

	// Timeout
	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/dpstep_pkg.sv
design/dpstep_core.sv
design/digipot_updown_stepper_top.sv
verif/digipot_updown_stepper_checker.sv
verif/digipot_updown_stepper_top_tb.sv
